@@ rtl/core/rpb_pkg.sv @@
// Shared types, constants and saturating helpers for the ray-plane back-projection block.
package rpb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_LAT   = 4;
  localparam int DIV_STEPS = 64 + FRAC_BITS;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int WAIT_W    = $clog2(DIV_LAT);

  typedef logic signed [31:0] q32_t;
  typedef logic signed [63:0] q64_t;

  localparam q64_t Q64_MAX = {1'b0, {63{1'b1}}};
  localparam q64_t Q64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SINGULAR  = 2'd1,
    ST_PARALLEL  = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef struct packed {
    q32_t img_u;
    q32_t img_v;
    q32_t img_w;
    q32_t plane_nx;
    q32_t plane_ny;
    q32_t plane_nz;
    q32_t plane_offset;
  } item_in_t;

  typedef struct packed {
    q32_t    world_x;
    q32_t    world_y;
    q32_t    world_z;
    status_t status;
  } result_t;

  typedef struct packed {
    logic sat;
    q64_t v;
  } satv_t;

  // Per-matrix values shared by all items
  typedef struct packed {
    logic         singular;
    logic         sat;
    q64_t [8:0]   inv;
    q64_t [2:0]   cen;
  } setup_t;

  function automatic q64_t sx32(logic [31:0] x);
    return q64_t'({{32{x[31]}}, x});
  endfunction

  function automatic logic [63:0] mag(q64_t a);
    logic [63:0] u;
    u = a;
    return a[63] ? (~u + 64'd1) : u;
  endfunction

  function automatic satv_t sat_add(q64_t a, q64_t b);
    satv_t       r;
    logic [63:0] s;
    s = a + b;
    r.sat = (a[63] == b[63]) && (s[63] != a[63]);
    r.v = r.sat ? (a[63] ? Q64_MIN : Q64_MAX) : q64_t'(s);
    return r;
  endfunction

  function automatic satv_t sat_neg(q64_t a);
    satv_t r;
    r.sat = (a == Q64_MIN);
    r.v = r.sat ? Q64_MAX : -a;
    return r;
  endfunction

  // Next index modulo three
  function automatic logic [1:0] nxt3(logic [1:0] x);
    logic [1:0] r;
    case (x)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] idx3(logic [1:0] r, logic [1:0] c);
    return 4'({2'b00, r} * 4'd3 + {2'b00, c});
  endfunction

endpackage

@@ rtl/core/rpb_qmul.sv @@
// Pipelined Q.F multiplier: 64x64 from four 32x32 partial products, floor shift, saturation.
module rpb_qmul (
  input  logic         clk,
  input  logic         en,
  input  rpb_pkg::q64_t a,
  input  rpb_pkg::q64_t b,
  output rpb_pkg::q64_t p,
  output logic         sat
);
  import rpb_pkg::*;

  logic [63:0]  ua_r, ub_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] sum_r;
  logic [127:0] prod;
  logic [127:0] sh;
  logic         fits;
  q64_t         p_r;
  logic         sat_r;

  // Sign-apply, floor shift and range check of the exact product
  always_comb begin
    prod = neg3_r ? (~sum_r + 128'd1) : sum_r;
    sh   = 128'($signed(prod) >>> FRAC_BITS);
    fits = (&sh[127:63]) | ~(|sh[127:63]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= mag(a);
      ub_r   <= mag(b);
      neg1_r <= a[63] ^ b[63];
      p00_r  <= {32'd0, ua_r[31:0]}  * {32'd0, ub_r[31:0]};
      p01_r  <= {32'd0, ua_r[31:0]}  * {32'd0, ub_r[63:32]};
      p10_r  <= {32'd0, ua_r[63:32]} * {32'd0, ub_r[31:0]};
      p11_r  <= {32'd0, ua_r[63:32]} * {32'd0, ub_r[63:32]};
      neg2_r <= neg1_r;
      sum_r  <= {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
              + {p11_r, 64'd0};
      neg3_r <= neg2_r;
      p_r    <= fits ? q64_t'(sh[63:0]) : (prod[127] ? Q64_MIN : Q64_MAX);
      sat_r  <= !fits;
    end
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule

@@ rtl/core/rpb_qdiv.sv @@
// Pipelined Q.F divider: one restoring step per stage, truncation toward zero, saturation.
module rpb_qdiv (
  input  logic         clk,
  input  logic         en,
  input  rpb_pkg::q64_t a,
  input  rpb_pkg::q64_t b,
  output rpb_pkg::q64_t q,
  output logic         sat
);
  import rpb_pkg::*;

  logic [63:0]          rem_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] nq_r  [DIV_STEPS+1];
  logic [63:0]          ub_r  [DIV_STEPS+1];
  logic                 neg_r [DIV_STEPS+1];
  logic                 bz_r  [DIV_STEPS+1];
  logic [63:0]          qlo;
  logic                 qhi_nz;
  q64_t                 q_r;
  logic                 sat_r;

  // Load the scaled dividend magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 64'd0;
      nq_r[0]  <= {mag(a), {FRAC_BITS{1'b0}}};
      ub_r[0]  <= mag(b);
      neg_r[0] <= a[63] ^ b[63];
      bz_r[0]  <= (b == '0);
    end
  end

  // One quotient bit per stage; dividend bits shift out as quotient bits shift in
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [64:0] rem2;
    logic        ge;
    always_comb begin
      rem2 = {rem_r[s], nq_r[s][DIV_STEPS-1]};
      ge   = rem2 >= {1'b0, ub_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? 64'(rem2 - {1'b0, ub_r[s]}) : rem2[63:0];
        nq_r[s+1]  <= {nq_r[s][DIV_STEPS-2:0], ge};
        ub_r[s+1]  <= ub_r[s];
        neg_r[s+1] <= neg_r[s];
        bz_r[s+1]  <= bz_r[s];
      end
    end
  end

  assign qlo    = nq_r[DIV_STEPS][63:0];
  assign qhi_nz = |nq_r[DIV_STEPS][DIV_STEPS-1:64];

  // Apply sign and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      if (bz_r[DIV_STEPS]) begin
        q_r   <= '0;
        sat_r <= 1'b1;
      end else if (neg_r[DIV_STEPS]) begin
        if (qhi_nz || (qlo > {1'b1, 63'd0})) begin
          q_r   <= Q64_MIN;
          sat_r <= 1'b1;
        end else begin
          q_r   <= q64_t'(~qlo + 64'd1);
          sat_r <= 1'b0;
        end
      end else if (qhi_nz || qlo[63]) begin
        q_r   <= Q64_MAX;
        sat_r <= 1'b1;
      end else begin
        q_r   <= q64_t'(qlo);
        sat_r <= 1'b0;
      end
    end
  end

  assign q   = q_r;
  assign sat = sat_r;

endmodule

@@ rtl/core/rpb_setup.sv @@
// Matrix setup sequencer: adjugate, determinant, inverse and camera centre from the registers.
module rpb_setup (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [rpb_pkg::NUM_REGS-1:0][63:0]    regs,
  output logic                                  busy,
  output rpb_pkg::setup_t                       setup
);
  import rpb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADJ_A, S_ADJ_AW, S_ADJ_B, S_ADJ_BW, S_DET, S_DET_W,
    S_INV, S_INV_W, S_CEN, S_CEN_W
  } state_t;

  state_t            state_r;
  logic [1:0]        row_r, col_r;
  logic [WAIT_W-1:0] wait_r;
  q64_t              t1_r, acc_r, det_r;
  q64_t              adj_r [9];
  q64_t              inv_r [9];
  q64_t              cen_r [3];
  logic              sing_r, sat_r;

  q64_t  m [9];
  q64_t  p [3];
  q64_t  mul_a, mul_b, mul_p, div_q;
  logic  mul_sat, div_sat;
  logic  last;
  satv_t negv, nadj, dacc, cneg;
  logic [1:0] r1, r2, c1, c2;

  // Unpack M and p
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[3*i]   = sx32(regs[2*i][31:0]);
      m[3*i+1] = sx32(regs[2*i][63:32]);
      m[3*i+2] = sx32(regs[2*i+1][31:0]);
      p[i]     = sx32(regs[2*i+1][63:32]);
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    r1 = nxt3(row_r);
    r2 = nxt3(r1);
    c1 = nxt3(col_r);
    c2 = nxt3(c1);
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ADJ_A: begin
        mul_a = m[idx3(c1, r1)];
        mul_b = m[idx3(c2, r2)];
      end
      S_ADJ_B: begin
        mul_a = m[idx3(c1, r2)];
        mul_b = m[idx3(c2, r1)];
      end
      S_DET: begin
        mul_a = m[idx3(2'd0, col_r)];
        mul_b = adj_r[idx3(col_r, 2'd0)];
      end
      S_CEN: begin
        mul_a = inv_r[idx3(row_r, col_r)];
        mul_b = p[col_r];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    last = (row_r == 2'd2) && (col_r == 2'd2);
    negv = sat_neg(mul_p);
    nadj = sat_add(t1_r, negv.v);
    dacc = sat_add(acc_r, mul_p);
    cneg = sat_neg(dacc.v);
  end

  rpb_qmul u_mul (
    .clk (clk),
    .en  (1'b1),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p),
    .sat (mul_sat)
  );

  rpb_qdiv u_div (
    .clk (clk),
    .en  (1'b1),
    .a   (adj_r[idx3(row_r, col_r)]),
    .b   (det_r),
    .q   (div_q),
    .sat (div_sat)
  );

  // Sequencer: issue one operation, wait for its result, fold it in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= 2'd0;
      col_r   <= 2'd0;
      wait_r  <= '0;
      sing_r  <= 1'b1;
      sat_r   <= 1'b0;
    end else if (start) begin
      state_r <= S_ADJ_A;
      row_r   <= 2'd0;
      col_r   <= 2'd0;
      sing_r  <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: ;
        S_ADJ_A, S_ADJ_B, S_DET, S_CEN: begin
          wait_r  <= WAIT_W'(MUL_LAT - 1);
          state_r <= state_t'(state_r + 4'd1);
        end
        S_INV: begin
          wait_r  <= WAIT_W'(DIV_LAT - 1);
          state_r <= S_INV_W;
        end
        S_ADJ_AW: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - 1'b1;
          end else begin
            t1_r    <= mul_p;
            sat_r   <= sat_r | mul_sat;
            state_r <= S_ADJ_B;
          end
        end
        S_ADJ_BW: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - 1'b1;
          end else begin
            adj_r[idx3(row_r, col_r)] <= nadj.v;
            sat_r <= sat_r | mul_sat | negv.sat | nadj.sat;
            col_r <= (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
            if (col_r == 2'd2) row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
            if (last) begin
              acc_r   <= '0;
              state_r <= S_DET;
            end else begin
              state_r <= S_ADJ_A;
            end
          end
        end
        S_DET_W: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - 1'b1;
          end else begin
            acc_r <= dacc.v;
            sat_r <= sat_r | mul_sat | dacc.sat;
            if (col_r == 2'd2) begin
              det_r <= dacc.v;
              col_r <= 2'd0;
              row_r <= 2'd0;
              if (dacc.v == '0) begin
                sing_r  <= 1'b1;
                state_r <= S_IDLE;
              end else begin
                state_r <= S_INV;
              end
            end else begin
              col_r   <= col_r + 2'd1;
              state_r <= S_DET;
            end
          end
        end
        S_INV_W: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - 1'b1;
          end else begin
            inv_r[idx3(row_r, col_r)] <= div_q;
            sat_r <= sat_r | div_sat;
            col_r <= (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
            if (col_r == 2'd2) row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
            if (last) begin
              acc_r   <= '0;
              state_r <= S_CEN;
            end else begin
              state_r <= S_INV;
            end
          end
        end
        S_CEN_W: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - 1'b1;
          end else begin
            col_r <= (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
            if (col_r == 2'd2) begin
              row_r        <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
              cen_r[row_r] <= cneg.v;
              acc_r        <= '0;
              sat_r        <= sat_r | mul_sat | dacc.sat | cneg.sat;
            end else begin
              acc_r <= dacc.v;
              sat_r <= sat_r | mul_sat | dacc.sat;
            end
            state_r <= last ? S_IDLE : S_CEN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Publish the setup results
  always_comb begin
    setup.singular = sing_r;
    setup.sat      = sat_r;
    for (int k = 0; k < 9; k++) setup.inv[k] = inv_r[k];
    for (int i = 0; i < 3; i++) setup.cen[i] = cen_r[i];
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/core/rpb_ray.sv @@
// Per-item datapath: ray direction, plane terms, lambda divide and intersection point.
module rpb_ray (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  rpb_pkg::item_in_t in_item,
  input  rpb_pkg::setup_t   setup,
  output logic              res_valid,
  output rpb_pkg::result_t  res
);
  import rpb_pkg::*;

  typedef struct packed {
    q64_t [2:0] n;
    q64_t       d;
  } side_a_t;

  typedef struct packed {
    q64_t [2:0] n;
    q64_t [2:0] dir;
    q64_t       s1;
    logic       sat;
  } side_b_t;

  typedef struct packed {
    q64_t [2:0] dir;
    q64_t       s1;
    logic       sat;
  } side_c_t;

  typedef struct packed {
    q64_t [2:0] dir;
    logic       sat;
    logic       s2z;
  } side_f_t;

  typedef struct packed {
    logic sat;
    logic s2z;
  } side_g_t;

  // Segment A: inv*y and n*c
  q64_t  y3 [3];
  q64_t  n3 [3];
  q64_t  a_x [12];
  q64_t  a_y [12];
  q64_t  a_p [12];
  logic [11:0]        a_sat;
  logic [MUL_LAT-1:0] a_vld_r;
  side_a_t            a_side_r [MUL_LAT];

  // Stage B
  logic    b_vld_r;
  side_b_t b_r, b_nxt;

  // Segment C: n*dir
  q64_t               c_p [3];
  logic [2:0]         c_sat;
  logic [MUL_LAT-1:0] c_vld_r;
  side_c_t            c_side_r [MUL_LAT];

  // Stage E
  logic    e_vld_r;
  q64_t    e_num_r, e_den_r, e_num_nxt, e_den_nxt;
  side_f_t e_side_r, e_side_nxt;

  // Segment F: lambda divide
  q64_t               lam;
  logic               lam_sat;
  logic [DIV_LAT-1:0] f_vld_r;
  side_f_t            f_side_r [DIV_LAT];

  // Segment G: lambda*dir
  q64_t               g_p [3];
  logic [2:0]         g_sat;
  logic [MUL_LAT-1:0] g_vld_r;
  side_g_t            g_side_r [MUL_LAT];

  // Stage H
  logic    h_vld_r;
  result_t h_r, h_nxt;

  always_comb begin
    y3[0] = sx32(in_item.img_u);
    y3[1] = sx32(in_item.img_v);
    y3[2] = sx32(in_item.img_w);
    n3[0] = sx32(in_item.plane_nx);
    n3[1] = sx32(in_item.plane_ny);
    n3[2] = sx32(in_item.plane_nz);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a_x[3*i+j] = setup.inv[3*i+j];
        a_y[3*i+j] = y3[j];
      end
      a_x[9+i] = n3[i];
      a_y[9+i] = setup.cen[i];
    end
  end

  for (genvar k = 0; k < 12; k++) begin : g_mul_a
    rpb_qmul u_mul (.clk(clk), .en(en), .a(a_x[k]), .b(a_y[k]), .p(a_p[k]), .sat(a_sat[k]));
  end

  for (genvar k = 0; k < 3; k++) begin : g_mul_c
    rpb_qmul u_mul (.clk(clk), .en(en), .a(b_r.n[k]), .b(b_r.dir[k]),
                    .p(c_p[k]), .sat(c_sat[k]));
  end

  rpb_qdiv u_div (.clk(clk), .en(en), .a(e_num_r), .b(e_den_r), .q(lam), .sat(lam_sat));

  for (genvar k = 0; k < 3; k++) begin : g_mul_g
    rpb_qmul u_mul (.clk(clk), .en(en), .a(lam), .b(f_side_r[DIV_LAT-1].dir[k]),
                    .p(g_p[k]), .sat(g_sat[k]));
  end

  // Sum dot products for the direction and the centre term
  always_comb begin
    satv_t da, db, s0, s1v, s2v;
    logic  sat;
    sat = |a_sat;
    for (int i = 0; i < 3; i++) begin
      da = sat_add(a_p[3*i], a_p[3*i+1]);
      db = sat_add(da.v, a_p[3*i+2]);
      b_nxt.dir[i] = db.v;
      b_nxt.n[i]   = a_side_r[MUL_LAT-1].n[i];
      sat = sat | da.sat | db.sat;
    end
    s0  = sat_add(a_p[9], a_p[10]);
    s1v = sat_add(s0.v, a_p[11]);
    s2v = sat_add(s1v.v, a_side_r[MUL_LAT-1].d);
    b_nxt.s1  = s2v.v;
    b_nxt.sat = sat | s0.sat | s1v.sat | s2v.sat;
  end

  // Form the divide operands
  always_comb begin
    satv_t t0, t1, nn;
    t0 = sat_add(c_p[0], c_p[1]);
    t1 = sat_add(t0.v, c_p[2]);
    nn = sat_neg(c_side_r[MUL_LAT-1].s1);
    e_num_nxt      = nn.v;
    e_den_nxt      = t1.v;
    e_side_nxt.dir = c_side_r[MUL_LAT-1].dir;
    e_side_nxt.s2z = (t1.v == '0);
    e_side_nxt.sat = c_side_r[MUL_LAT-1].sat | (|c_sat) | t0.sat | t1.sat | nn.sat;
  end

  // Intersection point, range check and status
  always_comb begin
    satv_t xs [3];
    logic  sat;
    sat = g_side_r[MUL_LAT-1].sat | (|g_sat) | setup.sat;
    for (int i = 0; i < 3; i++) begin
      xs[i] = sat_add(setup.cen[i], g_p[i]);
      sat = sat | xs[i].sat | ~((&xs[i].v[63:31]) | ~(|xs[i].v[63:31]));
    end
    if (setup.singular)                 h_nxt.status = ST_SINGULAR;
    else if (g_side_r[MUL_LAT-1].s2z)   h_nxt.status = ST_PARALLEL;
    else if (sat)                       h_nxt.status = ST_SATURATED;
    else                                h_nxt.status = ST_OK;
    if (h_nxt.status == ST_OK) begin
      h_nxt.world_x = q32_t'(xs[0].v[31:0]);
      h_nxt.world_y = q32_t'(xs[1].v[31:0]);
      h_nxt.world_z = q32_t'(xs[2].v[31:0]);
    end else begin
      h_nxt.world_x = '0;
      h_nxt.world_y = '0;
      h_nxt.world_z = '0;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      b_vld_r <= 1'b0;
      c_vld_r <= '0;
      e_vld_r <= 1'b0;
      f_vld_r <= '0;
      g_vld_r <= '0;
      h_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= {a_vld_r[MUL_LAT-2:0], in_valid};
      b_vld_r <= a_vld_r[MUL_LAT-1];
      c_vld_r <= {c_vld_r[MUL_LAT-2:0], b_vld_r};
      e_vld_r <= c_vld_r[MUL_LAT-1];
      f_vld_r <= {f_vld_r[DIV_LAT-2:0], e_vld_r};
      g_vld_r <= {g_vld_r[MUL_LAT-2:0], f_vld_r[DIV_LAT-1]};
      h_vld_r <= g_vld_r[MUL_LAT-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) a_side_r[0].n[i] <= n3[i];
      a_side_r[0].d <= sx32(in_item.plane_offset);
      for (int s = 1; s < MUL_LAT; s++) a_side_r[s] <= a_side_r[s-1];
      b_r <= b_nxt;
      c_side_r[0].dir <= b_r.dir;
      c_side_r[0].s1  <= b_r.s1;
      c_side_r[0].sat <= b_r.sat;
      for (int s = 1; s < MUL_LAT; s++) c_side_r[s] <= c_side_r[s-1];
      e_num_r  <= e_num_nxt;
      e_den_r  <= e_den_nxt;
      e_side_r <= e_side_nxt;
      f_side_r[0] <= e_side_r;
      for (int s = 1; s < DIV_LAT; s++) f_side_r[s] <= f_side_r[s-1];
      g_side_r[0].sat <= f_side_r[DIV_LAT-1].sat | lam_sat;
      g_side_r[0].s2z <= f_side_r[DIV_LAT-1].s2z;
      for (int s = 1; s < MUL_LAT; s++) g_side_r[s] <= g_side_r[s-1];
      h_r <= h_nxt;
    end
  end

  assign res_valid = h_vld_r;
  assign res       = h_r;

endmodule

@@ rtl/core/camera_ray_plane_backprojection.sv @@
// Top level: configuration registers, setup sequencer, item pipeline and output skid stage.
//
// Back-projects a homogeneous image point through the configured 3x4 camera
// matrix onto the plane n.X + d = 0, all in signed Q16.16.
// Input channel in_valid/in_stall/in_data carries one point and plane per
// transfer; output channel out_valid/out_stall/out_data returns the point and
// a status code (ok, singular matrix, ray parallel to plane, saturated).
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0..5);
// other indexes are ignored. Each write starts the matrix setup sequencer
// (adjugate, determinant, nine divides, camera centre) on one shared
// multiplier and divider; its run is dominated by the nine serial divides,
// and it holds in_stall high meanwhile. Throughput: one item per cycle
// while in_stall is low. The item pipeline holds three 4-stage multiplier
// segments and the 66 + FRAC_BITS stage lambda divider.
// Reset clears the configuration registers to zero; the matrix is then
// marked singular and no setup pass is needed. When the receiver stalls,
// one result parks in the skid register and in_stall rises with it; the
// pipeline freezes until the output drains, losing or repeating nothing.
module camera_ray_plane_backprojection (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rpb_pkg::item_in_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rpb_pkg::result_t                 out_data,
  input  logic                             cfg_we,
  input  logic [rpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_wdata
);
  import rpb_pkg::*;

  logic [NUM_REGS-1:0][63:0] cfg_regs_r;
  logic    cfg_hit;
  logic    busy;
  setup_t  setup;
  logic    en;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    out_take;

  assign cfg_hit = cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS));

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_regs_r <= '0;
    end else if (cfg_hit) begin
      cfg_regs_r[cfg_index] <= cfg_wdata;
    end
  end

  rpb_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_hit),
    .regs  (cfg_regs_r),
    .busy  (busy),
    .setup (setup)
  );

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r || busy;

  rpb_ray u_ray (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid && !busy),
    .in_item   (in_data),
    .setup     (setup),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_take = out_valid_r && !out_stall;

  // Output register with skid: park a result while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A parked result implies a waiting output
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid full without output valid");

  // A parked result stays while the receiver stalls
  assert property (@(posedge clk) disable iff (!rst_n)
                   (skid_valid_r && out_stall) |=> skid_valid_r)
    else $error("skid result dropped during stall");

  // Error results carry zero coordinates
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && (out_data_r.status != ST_OK)) |->
                   (out_data_r.world_x == '0 && out_data_r.world_y == '0 &&
                    out_data_r.world_z == '0))
    else $error("nonzero coordinates on error status");

endmodule

@@ tb/tb_camera_ray_plane_backprojection.sv @@
// Self-checking testbench for the camera ray-plane back-projection block.
`timescale 1ns / 1ps

module tb_camera_ray_plane_backprojection;
  import rpb_pkg::*;

  localparam int TIMEOUT_CYC = 600000;
  localparam int DRAIN_CYC   = 130;
  localparam int F           = FRAC_BITS;
  localparam int ONE         = 1 << F;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  item_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  result_t              out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_wdata;

  camera_ray_plane_backprojection DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  item_in_t    pending_items[$];
  result_t     expected_points[$];
  logic [63:0] cam_regs[NUM_REGS];
  int          cyc;
  int          mismatches;
  bit          sat_hit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic logic [63:0] fx_mag(q64_t a);
    logic [63:0] u;
    u = a;
    return a[63] ? (~u + 64'd1) : u;
  endfunction

  function automatic q64_t fx_add(q64_t a, q64_t b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_hit = 1'b1;
      return a[63] ? Q64_MIN : Q64_MAX;
    end
    return q64_t'(s);
  endfunction

  function automatic q64_t fx_neg(q64_t a);
    if (a == Q64_MIN) begin
      sat_hit = 1'b1;
      return Q64_MAX;
    end
    return -a;
  endfunction

  // Exact product, floor shift by F, saturate to 64 bits
  function automatic q64_t fx_mul(q64_t a, q64_t b);
    logic signed [127:0] p;
    logic signed [127:0] r;
    p = a;
    p = p * b;
    r = p >>> F;
    if (r[127:63] != {65{r[63]}}) begin
      sat_hit = 1'b1;
      return r[127] ? Q64_MIN : Q64_MAX;
    end
    return q64_t'(r[63:0]);
  endfunction

  // (a << F) / b truncated toward zero, saturated
  function automatic q64_t fx_div(q64_t a, q64_t b);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [63:0]  lo;
    num = {64'd0, fx_mag(a)} << F;
    den = {64'd0, fx_mag(b)};
    if (den == 0) begin
      sat_hit = 1'b1;
      return '0;
    end
    q = num / den;
    lo = q[63:0];
    if (a[63] != b[63]) begin
      if (q > (128'd1 << 63)) begin
        sat_hit = 1'b1;
        return Q64_MIN;
      end
      return q64_t'(-lo);
    end
    if (q[127:63] != 0) begin
      sat_hit = 1'b1;
      return Q64_MAX;
    end
    return q64_t'(lo);
  endfunction

  function automatic q64_t fx_dot3(q64_t a0, q64_t a1, q64_t a2, q64_t b0, q64_t b1, q64_t b2);
    return fx_add(fx_add(fx_mul(a0, b0), fx_mul(a1, b1)), fx_mul(a2, b2));
  endfunction

  function automatic result_t project_point(item_in_t it);
    q64_t    m[3][3];
    q64_t    adj[3][3];
    q64_t    inv[3][3];
    q64_t    pv[3], y[3], n[3], c[3], dr[3], x[3];
    q64_t    det, d, s1, s2, lam;
    status_t st;
    result_t r;
    sat_hit = 1'b0;
    st = ST_OK;
    for (int i = 0; i < 3; i++) begin
      m[i][0] = sx32(cam_regs[2*i][31:0]);
      m[i][1] = sx32(cam_regs[2*i][63:32]);
      m[i][2] = sx32(cam_regs[2*i+1][31:0]);
      pv[i]   = sx32(cam_regs[2*i+1][63:32]);
      x[i]    = '0;
    end
    y[0] = it.img_u;    y[1] = it.img_v;    y[2] = it.img_w;
    n[0] = it.plane_nx; n[1] = it.plane_ny; n[2] = it.plane_nz;
    d = it.plane_offset;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[i][j] = fx_add(fx_mul(m[(j+1)%3][(i+1)%3], m[(j+2)%3][(i+2)%3]),
                           fx_neg(fx_mul(m[(j+1)%3][(i+2)%3], m[(j+2)%3][(i+1)%3])));
    det = fx_add(fx_add(fx_mul(m[0][0], adj[0][0]), fx_mul(m[0][1], adj[1][0])),
                 fx_mul(m[0][2], adj[2][0]));
    if (det == 0) begin
      st = ST_SINGULAR;
    end else begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          inv[i][j] = fx_div(adj[i][j], det);
      for (int i = 0; i < 3; i++) begin
        c[i]  = fx_neg(fx_dot3(inv[i][0], inv[i][1], inv[i][2], pv[0], pv[1], pv[2]));
        dr[i] = fx_dot3(inv[i][0], inv[i][1], inv[i][2], y[0], y[1], y[2]);
      end
      s1 = fx_add(fx_dot3(n[0], n[1], n[2], c[0], c[1], c[2]), d);
      s2 = fx_dot3(n[0], n[1], n[2], dr[0], dr[1], dr[2]);
      if (s2 == 0) begin
        st = ST_PARALLEL;
      end else begin
        lam = fx_div(fx_neg(s1), s2);
        for (int i = 0; i < 3; i++) begin
          x[i] = fx_add(c[i], fx_mul(lam, dr[i]));
          if (x[i] > 64'sd2147483647 || x[i] < -64'sd2147483648) sat_hit = 1'b1;
        end
        if (sat_hit) st = ST_SATURATED;
      end
    end
    r.status  = st;
    r.world_x = (st == ST_OK) ? x[0][31:0] : '0;
    r.world_y = (st == ST_OK) ? x[1][31:0] : '0;
    r.world_z = (st == ST_OK) ? x[2][31:0] : '0;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  // Signed value uniform in [-span, span]
  function automatic q32_t rnd_span(int unsigned span);
    return q32_t'($urandom_range(0, 2 * span)) - q32_t'(span);
  endfunction

  function automatic item_in_t noise_item();
    item_in_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  // Plausible point and plane with random content
  function automatic item_in_t scene_item();
    item_in_t it;
    it.img_u        = rnd_span(200 * ONE);
    it.img_v        = rnd_span(200 * ONE);
    it.img_w        = ($urandom_range(0, 3) == 0) ? rnd_span(4 * ONE) : q32_t'(ONE);
    it.plane_nx     = rnd_span(2 * ONE);
    it.plane_ny     = rnd_span(2 * ONE);
    it.plane_nz     = rnd_span(2 * ONE);
    it.plane_offset = rnd_span(50 * ONE);
    return it;
  endfunction

  function automatic item_in_t mk_item(int u, int v, int w, int nx, int ny, int nz, int d);
    item_in_t it;
    it = {u, v, w, nx, ny, nz, d};
    return it;
  endfunction

  function automatic logic [31:0] well_word(bit diag);
    if (diag) return ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) *
                     q32_t'($urandom_range(ONE, 4 * ONE));
    return rnd_span(ONE / 2);
  endfunction

  task automatic cfg_write(int idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_wdata <= val;
    if (idx < NUM_REGS) cam_regs[idx] = val;
  endtask

  task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] r3, logic [63:0] r4, logic [63:0] r5);
    cfg_write(0, r0); cfg_write(1, r1); cfg_write(2, r2);
    cfg_write(3, r3); cfg_write(4, r4); cfg_write(5, r5);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_well_matrix();
    logic [63:0] rv[6];
    for (int i = 0; i < 3; i++) begin
      logic [31:0] c0, c1, c2;
      c0 = well_word(i == 0);
      c1 = well_word(i == 1);
      c2 = well_word(i == 2);
      rv[2*i]   = {c1, c0};
      rv[2*i+1] = {rnd_span(20 * ONE), c2};
    end
    load_matrix(rv[0], rv[1], rv[2], rv[3], rv[4], rv[5]);
  endtask

  // Hold until every queued item has transferred and every result has come back
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_points.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic push_random(int count);
    for (int k = 0; k < count; k++)
      pending_items.push_back(($urandom_range(0, 99) < 80) ? scene_item() : noise_item());
  endtask

  // ---------------- main sequence ----------------
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < NUM_REGS; i++) cam_regs[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zero matrix after reset: singular
    pending_items.push_back(mk_item(ONE, ONE, ONE, ONE, 0, 0, 0));
    pending_items.push_back(noise_item());
    drain();

    // Identity camera at the origin
    load_matrix({32'd0, 32'(ONE)}, 64'd0, {32'(ONE), 32'd0}, 64'd0, 64'd0, {32'd0, 32'(ONE)});
    cfg_write(6, 64'hFFFF_FFFF_FFFF_FFFF);  // unused index, ignored
    cfg_write(7, 64'h0);
    @(posedge clk);
    cfg_we <= 1'b0;
    pending_items.push_back(mk_item(0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(ONE, 2 * ONE, ONE, 0, 0, ONE, -5 * ONE));
    pending_items.push_back(mk_item(ONE, 0, ONE, 0, ONE, 0, ONE));          // parallel ray
    pending_items.push_back(mk_item(ONE, 0, ONE, 1, 0, 0, 32'h7FFF_FFFF));  // saturated
    pending_items.push_back(mk_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_items.push_back(mk_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(mk_item(32'hFFFF_FFFF, 1, -1, -ONE, ONE, ONE, 3 * ONE));
    pending_items.push_back(mk_item(-3 * ONE, 7 * ONE, 2 * ONE, ONE, ONE, ONE, -ONE));
    pending_items.push_back(mk_item(ONE, ONE, 0, 0, 0, ONE, -ONE));         // point at infinity
    push_random(60);
    drain();

    // Extreme matrices
    load_matrix({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}});
    push_random(8);
    drain();
    load_matrix({32'h8000_0000, 32'h7FFF_FFFF}, {32'h8000_0000, 32'h0000_0001},
                {32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
                {32'h0000_0001, 32'h8000_0000}, {32'h8000_0000, 32'h7FFF_FFFF});
    push_random(8);
    drain();

    // Fully random words
    load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    push_random(20);
    drain();

    // Rank-deficient: row 2 of the 3x3 part equals row 0
    load_matrix({32'(2 * ONE), 32'(ONE)}, {32'(5 * ONE), 32'(3 * ONE)}, {32'(ONE), 32'd0},
                {32'd0, 32'(ONE)}, {32'(2 * ONE), 32'(ONE)}, {32'(-ONE), 32'(3 * ONE)});
    push_random(10);
    drain();

    // Several well-conditioned cameras carry most of the random traffic
    for (int ph = 0; ph < 5; ph++) begin
      load_well_matrix();
      push_random(40);
      drain();           // sender holds off until all results are back
      push_random(45);
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin
    bit quiet;
    quiet = (cyc > 2000 && cyc < 9000);
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) expected_points.push_back(project_point(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    result_t want;
    bit      quiet;
    quiet = (cyc > 4000 && cyc < 11000);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 15);
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %h", out_data);
        end else begin
          want = expected_points.pop_front();
          if (out_data.world_x !== want.world_x || out_data.world_y !== want.world_y ||
              out_data.world_z !== want.world_z || out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                       want.world_x, want.world_y, want.world_z, want.status,
                       out_data.world_x, out_data.world_y, out_data.world_z, out_data.status);
          end
        end
      end
    end
  end

  // ---------------- timeout ----------------
  initial cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= TIMEOUT_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
